>>> rtl/core/fdas_pkg.sv
// Shared types and constants for the FIR-driven axis step block.
// Used by the register file, controller, datapath and top level.
package fdas_pkg;

  localparam int DATA_W    = 24;
  localparam int TAP_W     = 16;
  localparam int TAP_IDX_W = 2;   // taps 0..3 at most
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int STATUS_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_MAX    = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_COMMIT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEL_BAD = 2'd2;
  localparam logic [STATUS_W-1:0] ST_VEL_BAD   = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0]         taps;
    logic [15:0]              step_size;
    logic signed [DATA_W-1:0] vel_min;
    logic signed [DATA_W-1:0] vel_max;
    logic signed [DATA_W-1:0] acc_min;
    logic signed [DATA_W-1:0] acc_max;
    logic signed [DATA_W-1:0] in_min;
    logic signed [DATA_W-1:0] in_max;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ROUND,
    S_VMUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_tap;
    logic                 mul_step;
    logic                 round;
    logic                 finish;
    logic [TAP_IDX_W-1:0] tap_idx;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
  } sts_t;

endpackage

>>> rtl/core/fir_driven_axis_step_unit.sv
// FIR-driven axis step: top level joining registers, controller and datapath.
// One shared multiplier handles each tap and then the time-step product in turn,
// and a new input is taken only after the previous item has finished; a rejected
// input skips the multiply steps. Synchronous reset restores the default limits,
// clears taps, velocity, acceleration and input history, and empties the result.
module fir_driven_axis_step_unit
  import fdas_pkg::*;
#(
  parameter int TAPS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] drive_input,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      step_status,
  output logic signed [DATA_W-1:0] velocity_out,
  output logic signed [DATA_W-1:0] accel_out
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fdas_cfg_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fdas_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fdas_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .drive_input  (drive_input),
    .step_status  (step_status),
    .velocity_out (velocity_out),
    .accel_out    (accel_out)
  );

endmodule

>>> rtl/core/fdas_cfg_regs.sv
// Configuration register file for the axis step block.
// Depends on fdas_pkg for the register indexes and the cfg_t layout.
module fdas_cfg_regs
  import fdas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.taps      <= '0;
      cfg.step_size <= 16'd655;
      cfg.vel_min   <= 24'sh800000;
      cfg.vel_max   <= 24'sh7FFFFF;
      cfg.acc_min   <= 24'sh800000;
      cfg.acc_max   <= 24'sh7FFFFF;
      cfg.in_min    <= 24'sh800000;
      cfg.in_max    <= 24'sh7FFFFF;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TAPS:      cfg.taps      <= wr_data;
        CFG_STEP_SIZE: cfg.step_size <= wr_data[15:0];
        CFG_VEL_MIN:   cfg.vel_min   <= wr_data[DATA_W-1:0];
        CFG_VEL_MAX:   cfg.vel_max   <= wr_data[DATA_W-1:0];
        CFG_ACC_MIN:   cfg.acc_min   <= wr_data[DATA_W-1:0];
        CFG_ACC_MAX:   cfg.acc_max   <= wr_data[DATA_W-1:0];
        CFG_IN_MIN:    cfg.in_min    <= wr_data[DATA_W-1:0];
        CFG_IN_MAX:    cfg.in_max    <= wr_data[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/fdas_ctrl.sv
// Sequencing state machine for the axis step block.
// Depends on fdas_pkg for state_t, cmd_t and sts_t.
module fdas_ctrl
  import fdas_pkg::*;
#(
  parameter int TAPS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAPS - 1);

  state_t               state, state_next;
  logic [TAP_IDX_W-1:0] tap_cnt, tap_cnt_next;
  logic                 out_free;
  logic                 accept;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.in_bad ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        if (tap_cnt == LAST_TAP) begin
          state_next = S_ACC;
        end
      end
      S_ACC:   state_next = S_ROUND;
      S_ROUND: state_next = S_VMUL;
      S_VMUL:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != S_IDLE);
    cmd.load     = accept;
    cmd.mul_tap  = (state == S_MUL);
    cmd.mul_step = (state == S_VMUL);
    cmd.round    = (state == S_ROUND);
    cmd.finish   = (state == S_FIN) && out_free;
    cmd.tap_idx  = tap_cnt;
    tap_cnt_next = (state == S_MUL) ? tap_cnt + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tap_cnt   <= tap_cnt_next;
      out_valid <= cmd.finish || (out_valid && out_stall);
    end
  end

endmodule

>>> rtl/core/fdas_dp.sv
// Datapath of the axis step block: shared multiplier, FIR accumulator,
// limit checks, axis state and the result register. Depends on fdas_pkg.
module fdas_dp
  import fdas_pkg::*;
#(
  parameter int TAPS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic signed [DATA_W-1:0]   drive_input,
  output logic [STATUS_W-1:0]        step_status,
  output logic signed [DATA_W-1:0]   velocity_out,
  output logic signed [DATA_W-1:0]   accel_out
);

  localparam int HIST_D = TAPS - 1;
  localparam int HIDX_W = (HIST_D > 1) ? $clog2(HIST_D) : 1;
  localparam int PROD_W = 41;
  localparam int SUM_W  = 42;
  localparam int ACC_W  = SUM_W - 14;
  localparam int RVEL_W = SUM_W - 16;
  localparam int VEL_W  = 27;

  logic signed [DATA_W-1:0] hist [HIST_D];
  logic signed [DATA_W-1:0] cur_vel;
  logic signed [DATA_W-1:0] cur_acc;
  logic signed [DATA_W-1:0] drive_q;
  logic                     bad_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_add;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_q;

  logic signed [16:0]        mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic [TAP_IDX_W-1:0]      hsel;
  logic signed [TAP_W-1:0]   tap;
  logic signed [SUM_W-1:0]   sum_rnd;
  logic signed [SUM_W-1:0]   prod_rnd;
  logic signed [RVEL_W-1:0]  dvel;
  logic signed [VEL_W-1:0]   vel_full;
  logic                      acc_bad;
  logic                      vel_bad;
  logic [STATUS_W-1:0]       status;

  // Input and limit checks are made on the item as it arrives.
  assign sts.in_bad = (cfg.vel_min > cfg.vel_max) || (cfg.acc_min > cfg.acc_max) ||
                      (cfg.in_min > cfg.in_max) || (cfg.step_size == 16'd0) ||
                      (drive_input < cfg.in_min) || (drive_input > cfg.in_max);

  always_comb begin
    tap   = cfg.taps[TAP_W*cmd.tap_idx +: TAP_W];
    hsel  = (cmd.tap_idx == '0) ? '0 : cmd.tap_idx - 1'b1;
    mul_a = cmd.mul_step ? $signed({1'b0, cfg.step_size}) : 17'(tap);
    if (cmd.mul_step) begin
      mul_b = acc_q[DATA_W-1:0];
    end else if (cmd.tap_idx == '0) begin
      mul_b = drive_q;
    end else begin
      mul_b = hist[hsel[HIDX_W-1:0]];
    end
  end

  // Floor of (x + half) >> s gives round to nearest, ties upward.
  assign sum_rnd  = sum + SUM_W'(signed'(8192));
  assign prod_rnd = SUM_W'(prod_q) + SUM_W'(signed'(32768));
  assign dvel     = prod_rnd[SUM_W-1:16];
  assign vel_full = VEL_W'(cur_vel) + VEL_W'(dvel);

  assign acc_bad = (acc_q < ACC_W'(cfg.acc_min)) || (acc_q > ACC_W'(cfg.acc_max));
  assign vel_bad = (vel_full < VEL_W'(cfg.vel_min)) || (vel_full > VEL_W'(cfg.vel_max));

  always_comb begin
    if (bad_q) begin
      status = ST_INVALID;
    end else if (acc_bad) begin
      status = ST_ACCEL_BAD;
    end else if (vel_bad) begin
      status = ST_VEL_BAD;
    end else begin
      status = ST_COMMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      drive_q <= drive_input;
      bad_q   <= sts.in_bad;
    end
    if (cmd.mul_tap || cmd.mul_step) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd.load) begin
      sum <= '0;
    end else if (prod_add) begin
      sum <= sum + SUM_W'(prod_q);
    end
    if (cmd.round) begin
      acc_q <= sum_rnd[SUM_W-1:14];
    end
    if (cmd.finish) begin
      step_status  <= status;
      velocity_out <= (status == ST_COMMIT) ? vel_full[DATA_W-1:0] : cur_vel;
      accel_out    <= (status == ST_COMMIT) ? acc_q[DATA_W-1:0] : cur_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_add <= 1'b0;
      cur_vel  <= '0;
      cur_acc  <= '0;
      for (int i = 0; i < HIST_D; i++) begin
        hist[i] <= '0;
      end
    end else begin
      prod_add <= cmd.mul_tap;
      if (cmd.finish && (status == ST_COMMIT)) begin
        cur_vel <= vel_full[DATA_W-1:0];
        cur_acc <= acc_q[DATA_W-1:0];
        hist[0] <= drive_q;
        for (int i = 1; i < HIST_D; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end
  end

endmodule
